FILE: rtl/core/rahist_pkg.sv
// Shared types and constants of the radial angular-momentum histogram.
`default_nettype none

package rahist_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned MSUM_W    = 56;
  localparam int unsigned JSUM_W    = 64;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MASS_W    = 32;

  // Square-root datapath.
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RADIUS_W   = 31;
  localparam int unsigned SCALE_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_UNIT = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_MIN_RESET    = 31'd0;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX_RESET    = 31'd1966080;
  localparam logic [SCALE_W-1:0]  BINS_PER_UNIT_RESET = 32'd131072;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius_min;
    logic [RADIUS_W-1:0] radius_max;
    logic [SCALE_W-1:0]  bins_per_unit;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic [MASS_W-1:0]         mass;
  } particle_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0]     bin;
    logic [MASS_W-1:0]        mass;
    logic signed [JSUM_W-1:0] jz;
  } update_t;

endpackage

`default_nettype wire

FILE: rtl/core/rahist_if.sv
// Stream channel interfaces: particle/dump items in, bin beats out.
`default_nettype none

interface rahist_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [31:0] particle_mass;

  modport source (
    output valid, kind, pos_x, pos_y, vel_x, vel_y, particle_mass,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, vel_x, vel_y, particle_mass,
    output ready
  );
endinterface

interface rahist_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [31:0] particle_count;
  logic [55:0] mass_total;
  logic signed [63:0] jz_total;
  logic        last_bin;

  modport source (
    output valid, bin_index, particle_count, mass_total, jz_total, last_bin,
    input  ready
  );
  modport sink (
    input  valid, bin_index, particle_count, mass_total, jz_total, last_bin,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rahist_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none

module rahist_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rahist_pkg::SQ_W-1:0]  radicand,
  output logic                              done,
  output logic [rahist_pkg::ROOT_W-1:0]     root
);

  localparam int unsigned ROOT_W = rahist_pkg::ROOT_W;
  localparam int unsigned SQ_W   = rahist_pkg::SQ_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  opnd;
  logic [REM_W-1:0] rem;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_sub;
  logic             fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh  = {rem, opnd[SQ_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    rem_sub = rem_sh - trial;
    fits    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ROOT_W - 1);
        opnd    <= radicand;
        rem     <= '0;
        root    <= '0;
      end else if (running) begin
        opnd <= opnd << 2;
        rem  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], fits};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rahist_front.sv
// Particle front end: squares, jz, range test, radius root and bin mapping.
`default_nettype none

module rahist_front #(
  parameter int unsigned NUM_BINS      = 60,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire rahist_pkg::particle_t job,
  input  wire rahist_pkg::cfg_t      cfg,
  output logic                       busy,
  output logic                       upd_valid,
  output rahist_pkg::update_t        upd
);

  localparam int unsigned SHIFT = 32 - FRACTION_BITS;
  localparam int unsigned RW    = rahist_pkg::RADIUS_W;
  localparam logic [31:0] LAST_BIN = 32'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_SUM, F_ROOT, F_SCALE, F_BIN
  } state_t;

  state_t state;

  rahist_pkg::particle_t job_q;
  logic [63:0]          sqx;
  logic [63:0]          sqy;
  logic signed [63:0]   p_a;
  logic signed [63:0]   p_b;
  logic [2*RW-1:0]      rmin2;
  logic [2*RW-1:0]      rmax2;
  logic signed [63:0]   jz;
  logic [31:0]          diff;
  logic [63:0]          prod;

  logic [31:0]        ax;
  logic [31:0]        ay;
  logic signed [63:0] x_w;
  logic signed [63:0] y_w;
  logic signed [63:0] vx_w;
  logic signed [63:0] vy_w;
  logic [63:0]        sq;
  logic               in_range;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [rahist_pkg::ROOT_W-1:0] sqrt_root;
  logic [31:0]        rmin_w;
  logic [31:0]        diff_next;
  logic [31:0]        hi;

  always_comb begin
    ax   = job_q.pos_x[31] ? (~job_q.pos_x + 32'd1) : job_q.pos_x;
    ay   = job_q.pos_y[31] ? (~job_q.pos_y + 32'd1) : job_q.pos_y;
    x_w  = 64'(job_q.pos_x);
    y_w  = 64'(job_q.pos_y);
    vx_w = 64'(job_q.vel_x);
    vy_w = 64'(job_q.vel_y);
    sq       = sqx + sqy;
    in_range = (sq > {2'b00, rmin2}) && (sq < {2'b00, rmax2});
    sqrt_start = (state == F_SUM) && in_range;
    rmin_w    = {1'b0, cfg.radius_min};
    diff_next = (sqrt_root > rmin_w) ? (sqrt_root - rmin_w) : '0;
    hi        = prod[63:32];
  end

  rahist_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            job_q <= job;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          sqx   <= ax * ax;
          sqy   <= ay * ay;
          p_a   <= vy_w * x_w;
          p_b   <= vx_w * y_w;
          rmin2 <= cfg.radius_min * cfg.radius_min;
          rmax2 <= cfg.radius_max * cfg.radius_max;
          state <= F_SUM;
        end
        F_SUM: begin
          jz    <= (p_a >>> SHIFT) - (p_b >>> SHIFT);
          state <= in_range ? F_ROOT : F_IDLE;
        end
        F_ROOT: begin
          if (sqrt_done) begin
            diff  <= diff_next;
            state <= F_SCALE;
          end
        end
        F_SCALE: begin
          prod  <= diff * cfg.bins_per_unit;
          state <= F_BIN;
        end
        F_BIN: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state != F_IDLE);
  assign upd_valid = (state == F_BIN);
  assign upd.bin   = (hi > LAST_BIN) ? rahist_pkg::BIN_IDX_W'(NUM_BINS - 1)
                                     : hi[rahist_pkg::BIN_IDX_W-1:0];
  assign upd.mass  = job_q.mass;
  assign upd.jz    = jz;

endmodule

`default_nettype wire

FILE: rtl/core/rahist_bins.sv
// Bin store: read-modify-write accumulation and ordered dump to the output.
`default_nettype none

module rahist_bins #(
  parameter int unsigned NUM_BINS = 60
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                upd_valid,
  input  wire rahist_pkg::update_t upd,
  input  wire logic                dump_start,
  output logic                     busy,
  rahist_out_if.source             out_ch
);

  localparam int unsigned BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CW     = rahist_pkg::COUNT_W;
  localparam int unsigned MW     = rahist_pkg::MSUM_W;
  localparam int unsigned JW     = rahist_pkg::JSUM_W;
  localparam logic [BIN_W-1:0] LAST = BIN_W'(NUM_BINS - 1);

  typedef struct packed {
    logic [CW-1:0]        count;
    logic [MW-1:0]        mass;
    logic signed [JW-1:0] jz;
  } entry_t;

  typedef enum logic [1:0] {B_IDLE, B_UPD, B_DRD, B_DLD} state_t;

  state_t              state;
  logic [BIN_W-1:0]    k;
  rahist_pkg::update_t upd_q;

  entry_t              mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld;
  entry_t              rd_q;
  logic                rd_vld;

  logic                out_valid;
  logic [BIN_W-1:0]    out_bin;
  entry_t              out_data;
  logic                out_last;

  logic             rd_en;
  logic [BIN_W-1:0] rd_addr;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  entry_t           cur;
  entry_t           nxt;
  logic [MW:0]      msum;
  logic signed [JW-1:0] jsum;
  logic             jovf;

  always_comb begin
    rd_en   = ((state == B_IDLE) && upd_valid) || ((state == B_DRD) && !out_valid);
    rd_addr = (state == B_IDLE) ? upd.bin[BIN_W-1:0] : k;
    wr_en   = (state == B_UPD);
    wr_addr = upd_q.bin[BIN_W-1:0];
    // Never-written entries read as zero.
    cur = rd_vld ? rd_q : '0;
    // Saturate every accumulator at its range limits.
    nxt.count = (cur.count == '1) ? cur.count : cur.count + 1'b1;
    msum      = {1'b0, cur.mass} + (MW + 1)'(upd_q.mass);
    nxt.mass  = msum[MW] ? '1 : msum[MW-1:0];
    jsum      = cur.jz + upd_q.jz;
    jovf      = (cur.jz[JW-1] == upd_q.jz[JW-1]) && (jsum[JW-1] != cur.jz[JW-1]);
    if (jovf) begin
      nxt.jz = upd_q.jz[JW-1] ? {1'b1, {(JW-1){1'b0}}} : {1'b0, {(JW-1){1'b1}}};
    end else begin
      nxt.jz = jsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (upd_valid) begin
            upd_q <= upd;
            state <= B_UPD;
          end else if (dump_start) begin
            k     <= '0;
            state <= B_DRD;
          end
        end
        B_UPD: begin
          state <= B_IDLE;
        end
        B_DRD: begin
          if (!out_valid) begin
            state <= B_DLD;
          end
        end
        B_DLD: begin
          out_valid <= 1'b1;
          out_bin   <= k;
          out_data  <= cur;
          out_last  <= (k == LAST);
          if (k == LAST) begin
            state <= B_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= B_DRD;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  assign busy                  = (state != B_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.bin_index      = rahist_pkg::BIN_IDX_W'(out_bin);
  assign out_ch.particle_count = out_data.count;
  assign out_ch.mass_total     = out_data.mass;
  assign out_ch.jz_total       = out_data.jz;
  assign out_ch.last_bin       = out_last;

  a_upd_when_idle: assert property (@(posedge clk) disable iff (rst)
    upd_valid |-> (state == B_IDLE) && !dump_start)
    else $error("bin update arrived while the store was busy");

  a_load_into_empty: assert property (@(posedge clk) disable iff (rst)
    (state == B_DLD) |-> !out_valid)
    else $error("dump load would overwrite a pending beat");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (state == B_DLD) |=> out_ch.valid)
    else $error("dump read did not reach the output register");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_bin) |->
      (out_ch.bin_index == rahist_pkg::BIN_IDX_W'(NUM_BINS - 1)))
    else $error("last flag on a bin other than the final one");

endmodule

`default_nettype wire

FILE: rtl/core/radial_angular_momentum_histogram_core.sv
// Flow: an out-of-range particle frees the input after the multiply and sum states, else
//   after the root, scale and bin states and the write-back; the 32-step root dominates.
// Throughput: one item at a time; ready returns once the bin write-back has landed.
// A dump sends NUM_BINS beats, each taking a memory read, an output load and a drain,
//   and the last beat may still wait while the next item enters.
// Reset: registers return to their defaults and per-bin valid bits clear at once.
`default_nettype none

module radial_angular_momentum_histogram_core #(
  parameter int unsigned NUM_BINS      = 60,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  rahist_in_if.sink                                   in_ch,
  rahist_out_if.source                                out_ch,
  input  wire logic                                   cfg_we,
  input  wire logic [rahist_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rahist_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rahist_pkg::cfg_t      cfg;
  rahist_pkg::particle_t job;
  rahist_pkg::update_t   upd;

  logic front_busy;
  logic bins_busy;
  logic upd_valid;
  logic accept;
  logic particle_start;
  logic dump_start;

  // Configuration registers; the user must write only while the block is idle, which the
  // block does not enforce; so no shadowing is needed. Unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_min    <= rahist_pkg::RADIUS_MIN_RESET;
      cfg.radius_max    <= rahist_pkg::RADIUS_MAX_RESET;
      cfg.bins_per_unit <= rahist_pkg::BINS_PER_UNIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rahist_pkg::CFG_RADIUS_MIN: begin
          cfg.radius_min <= cfg_data[rahist_pkg::RADIUS_W-1:0];
        end
        rahist_pkg::CFG_RADIUS_MAX: begin
          cfg.radius_max <= cfg_data[rahist_pkg::RADIUS_W-1:0];
        end
        rahist_pkg::CFG_BINS_PER_UNIT: begin
          cfg.bins_per_unit <= cfg_data[rahist_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Take a new beat only when both the front end and the store are free;
  // a finished dump beat parked in the output register does not block it.
  assign in_ch.ready    = !front_busy && !bins_busy;
  assign accept         = in_ch.valid && in_ch.ready;
  assign particle_start = accept && !in_ch.kind;
  assign dump_start     = accept && in_ch.kind;

  // Dump beats ignore the particle fields.
  assign job.pos_x = in_ch.pos_x;
  assign job.pos_y = in_ch.pos_y;
  assign job.vel_x = in_ch.vel_x;
  assign job.vel_y = in_ch.vel_y;
  assign job.mass  = in_ch.particle_mass;

  // Squares, jz, range test, root and bin number.
  rahist_front #(
    .NUM_BINS      (NUM_BINS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (particle_start),
    .job       (job),
    .cfg       (cfg),
    .busy      (front_busy),
    .upd_valid (upd_valid),
    .upd       (upd)
  );

  // Bin memory with saturating read-modify-write and the dump sequencer.
  rahist_bins #(
    .NUM_BINS (NUM_BINS)
  ) u_bins (
    .clk        (clk),
    .rst        (rst),
    .upd_valid  (upd_valid),
    .upd        (upd),
    .dump_start (dump_start),
    .busy       (bins_busy),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
